/* sv/vmt4_pkg.sv */
// ----------------------------------------------------------------------------
// vmt4_pkg: shared types and constants
// Word widths, stream field offsets and lane control for the 4x4 transform.
// ----------------------------------------------------------------------------
package vmt4_pkg;

   localparam int DATA_W   = 32;
   localparam int LANES    = 4;
   localparam int IDX_W    = 2;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int REQ_W    = 168;
   localparam int RSP_W    = LANES * DATA_W;

   // request tdata field offsets, lowest bit first
   localparam int ROW_LSB  = 0;
   localparam int COL_LSB  = ROW_LSB + IDX_W;
   localparam int ELEM_LSB = COL_LSB + IDX_W;
   localparam int VEC_LSB  = ELEM_LSB + DATA_W;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_XFORM = 1'b1
   } action_type;

   // pipeline advance strobes shared by all lanes
   typedef struct packed {
      logic adv1;
      logic adv2;
   } lane_ctl_type;

endpackage

/* sv/vmt4_lane.sv */
// ----------------------------------------------------------------------------
// vmt4_lane: one result column
// Four 32x32 signed products, registered, then summed at full precision.
// ----------------------------------------------------------------------------
module vmt4_lane
   import vmt4_pkg::*;
(
   input  logic         clock,
   input  lane_ctl_type ctl,
   input  word_type     vec [LANES],
   input  word_type     col [LANES],
   output sum_type      sum
);

   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic signed [PROD_W-1:0] prod_in [LANES];
   sum_type                  sum_ff;
   sum_type                  sum_in;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         prod_in[k] = $signed(vec[k]) * $signed(col[k]);
      end
   end

   assign sum_in = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1])
                 + SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]);

   always_ff @(posedge clock) begin
      if (ctl.adv1) begin
         prod_ff <= prod_in;
      end
      if (ctl.adv2) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

/* sv/vmt4_merge.sv */
// ----------------------------------------------------------------------------
// vmt4_merge: scale, clamp and output register
// Floors the column sums by the fraction width, clamps each to 32 bits,
// packs them into one result word and ORs the clamp flags into rsp_tuser.
// ----------------------------------------------------------------------------
module vmt4_merge
   import vmt4_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sum_type             sums [LANES],
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,
   output logic                rsp_tuser
);

   logic             valid_ff;
   logic             valid_in;
   logic [RSP_W-1:0] res_ff;
   logic [RSP_W-1:0] res_in;
   logic             sat_ff;
   logic             sat_in;

   assign in_ready = !valid_ff || rsp_tready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      sum_type    shifted;
      logic       fits;
      res_in = '0;
      sat_in = 1'b0;
      for (int c = 0; c < LANES; c++) begin
         // arithmetic shift is the floor toward minus infinity
         shifted = sums[c] >>> FRAC_BITS;
         fits    = (&shifted[SUM_W-1:DATA_W-1]) || !(|shifted[SUM_W-1:DATA_W-1]);
         if (fits) begin
            res_in[c*DATA_W +: DATA_W] = shifted[DATA_W-1:0];
         end else begin
            res_in[c*DATA_W +: DATA_W] = shifted[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                          : {1'b0, {(DATA_W-1){1'b1}}};
            sat_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = res_ff;
   assign rsp_tuser  = sat_ff;

endmodule

/* sv/vector_matrix_transform_4.sv */
// ----------------------------------------------------------------------------
// vector_matrix_transform_4: row vector times stored 4x4 matrix, Q16.16
//
// channel | dir | tdata (low bit up)                               | tuser
// req_    | in  | row 2, column 2, element 32, vec_x/y/z/w 32 each,| action
//         |     | 4 zero pad bits                                  |
// rsp_    | out | res_x, res_y, res_z, res_w, 32 bits each         | saturated
//
// One word per cycle in and out while rsp_tready is high. A transform
// word reaches rsp_ through three registers: multiply, column sum,
// scale and clamp.
// A load word writes one matrix element and is seen by the very next word.
// Reset clears the matrix and the pipeline.
// Back-pressure holds only the stages that are full; empty stages still fill.
// ----------------------------------------------------------------------------
module vector_matrix_transform_4
   import vmt4_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // row, column, element, vec_x..vec_w, pad
   input  logic             req_tuser,  // action
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // res_x, res_y, res_z, res_w
   output logic             rsp_tuser   // saturated
);

   localparam int MAT_N = LANES * LANES;

   word_type             mat_ff [MAT_N];
   logic                 v1_ff;
   logic                 v1_in;
   logic                 v2_ff;
   logic                 v2_in;
   logic                 ready1;
   logic                 ready2;
   logic                 merge_ready;
   logic                 load_acc;
   logic                 xform_acc;
   logic [2*IDX_W-1:0]   mat_idx;
   word_type             elem;
   word_type             vec [LANES];
   sum_type              sums [LANES];
   lane_ctl_type         ctl;

   assign mat_idx = {req_tdata[ROW_LSB +: IDX_W], req_tdata[COL_LSB +: IDX_W]};
   assign elem    = req_tdata[ELEM_LSB +: DATA_W];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         vec[k] = req_tdata[VEC_LSB + k*DATA_W +: DATA_W];
      end
   end

   assign ready2     = !v2_ff || merge_ready;
   assign ready1     = !v1_ff || ready2;
   assign req_tready = ready1;

   assign load_acc  = req_tvalid && req_tready && (action_type'(req_tuser) == ACT_LOAD);
   assign xform_acc = req_tvalid && req_tready && (action_type'(req_tuser) == ACT_XFORM);

   assign v1_in = ready1 ? xform_acc : v1_ff;
   assign v2_in = ready2 ? v1_ff : v2_ff;

   assign ctl.adv1 = xform_acc;
   assign ctl.adv2 = v1_ff && ready2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         for (int i = 0; i < MAT_N; i++) begin
            mat_ff[i] <= '0;
         end
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         if (load_acc) begin
            mat_ff[mat_idx] <= elem;
         end
      end
   end

   for (genvar c = 0; c < LANES; c++) begin : g_lane
      word_type col [LANES];
      for (genvar k = 0; k < LANES; k++) begin : g_tap
         assign col[k] = mat_ff[k*LANES + c];
      end
      vmt4_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .vec   (vec),
         .col   (col),
         .sum   (sums[c])
      );
   end

   vmt4_merge #(
      .FRAC_BITS (FRAC_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v2_ff),
      .in_ready   (merge_ready),
      .sums       (sums),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_xform_enters: assert property (@(posedge clock) disable iff (reset)
      xform_acc |=> v1_ff)
      else $error("accepted transform did not enter the multiply stage");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      load_acc |=> !v1_ff)
      else $error("load word produced a pipeline entry");

   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !merge_ready |=> v2_ff && $stable(sums[0]) && $stable(sums[LANES-1]))
      else $error("column sums lost while the output stalls");

   a_matrix_write: assert property (@(posedge clock) disable iff (reset)
      load_acc |=> mat_ff[$past(mat_idx)] == $past(elem))
      else $error("matrix element not written");

endmodule
